### src/jsd_pkg.sv
// Package for the JPEG SOF dimension scanner.
// Holds marker codes, phase and status types, and the item and result structs.
// No dependencies.
`default_nettype none

package jsd_pkg;

    // Marker bytes.
    localparam logic [7:0] MARK_PREFIX = 8'hFF;
    localparam logic [7:0] MARK_SOI    = 8'hD8;
    localparam logic [7:0] MARK_SOF_LO = 8'hC0;
    localparam logic [7:0] MARK_SOF_HI = 8'hCF;
    localparam logic [7:0] MARK_DHT    = 8'hC4;
    localparam logic [7:0] MARK_JPG    = 8'hC8;
    localparam logic [7:0] MARK_DAC    = 8'hCC;
    localparam logic [7:0] MARK_EOI    = 8'hD9;
    localparam logic [7:0] MARK_SOS    = 8'hDA;
    localparam logic [7:0] MARK_RST_LO = 8'hD0;
    localparam logic [7:0] MARK_RST_HI = 8'hD7;

    // Smallest segment length values of interest.
    localparam logic [15:0] LEN_MIN     = 16'd2;
    localparam logic [15:0] LEN_SOF_MIN = 16'd8;

    // Payload offsets that carry the frame dimensions.
    localparam logic [2:0] OFF_HEIGHT_HI = 3'd1;
    localparam logic [2:0] OFF_HEIGHT_LO = 3'd2;
    localparam logic [2:0] OFF_WIDTH_HI  = 3'd3;
    localparam logic [2:0] OFF_WIDTH_LO  = 3'd4;
    localparam logic [2:0] OFF_MAX       = 3'd7;

    // Count of leading bytes below which a final byte marks a short file.
    localparam logic [1:0] SEEN_MAX = 2'd3;

    typedef enum logic [2:0] {
        PH_START,
        PH_SOI2,
        PH_SCAN,
        PH_FILL,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_BAD_SOI
    } phase_t;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_SMALL     = 4'd1,
        ST_NO_SOI    = 4'd2,
        ST_TRUNC_LEN = 4'd3,
        ST_BAD_LEN   = 4'd4,
        ST_TRUNC_PAY = 4'd5,
        ST_BAD_SOF   = 4'd6,
        ST_ZERO_DIM  = 4'd7,
        ST_NO_SOF    = 4'd8
    } status_t;

    // One input byte with its end-of-file flag.
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } item_t;

    // One result of a file.
    typedef struct packed {
        status_t     status;
        logic [15:0] width;
        logic [15:0] height;
    } result_t;

    // True for the start-of-frame markers.
    function automatic logic is_frame_marker(input logic [7:0] m);
        logic in_range;
        in_range = (m >= MARK_SOF_LO) && (m <= MARK_SOF_HI);
        return in_range && (m != MARK_DHT) && (m != MARK_JPG) && (m != MARK_DAC);
    endfunction

endpackage

`default_nettype wire

### src/jsd_in_reg.sv
// Input register of the JPEG SOF dimension scanner.
// Holds one accepted byte until the parser consumes it. Depends on jsd_pkg.
`default_nettype none

module jsd_in_reg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire jsd_pkg::item_t in_item,
    input  wire logic          advance,
    output logic               held_valid,
    output jsd_pkg::item_t     held_item
);
    import jsd_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    // The register takes a new byte when empty or when its byte moves on.
    assign in_stall   = valid_reg && !advance;
    assign accept     = in_valid && !in_stall;
    assign valid_next = accept || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

`default_nettype wire

### src/jsd_parser.sv
// Marker parser of the JPEG SOF dimension scanner.
// Holds the per-file parse state and settles one result per file.
// Depends on jsd_pkg.
`default_nettype none

module jsd_parser (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            advance,
    input  wire jsd_pkg::item_t  item,
    output logic                 res_valid,
    output jsd_pkg::result_t     res
);
    import jsd_pkg::*;

    phase_t      phase_reg,   phase_next;
    logic [1:0]  seen_reg,    seen_next;
    logic [15:0] seglen_reg,  seglen_next;
    logic [15:0] left_reg,    left_next;
    logic [2:0]  offset_reg,  offset_next;
    logic        sof_reg,     sof_next;
    logic [15:0] height_reg,  height_next;
    logic [15:0] width_reg,   width_next;
    logic        given_reg,   given_next;

    logic [7:0]  b;
    logic        fin;
    logic        hit;
    status_t     st;
    logic [15:0] seglen_full;
    logic [15:0] pl;
    logic [15:0] left_dec;
    logic [15:0] dim_width;
    logic [15:0] dim_height;

    assign b   = item.data;
    assign fin = item.fin;

    // Next state and result for the byte at the parser input.
    always_comb
    begin
        phase_next  = phase_reg;
        seen_next   = (seen_reg < SEEN_MAX) ? seen_reg + 2'd1 : seen_reg;
        seglen_next = seglen_reg;
        left_next   = left_reg;
        offset_next = offset_reg;
        sof_next    = sof_reg;
        height_next = height_reg;
        width_next  = width_reg;
        given_next  = given_reg;
        hit         = 1'b0;
        st          = ST_OK;
        seglen_full = {seglen_reg[15:8], b};
        pl          = seglen_full - LEN_MIN;
        left_dec    = left_reg - 16'd1;

        if (!given_reg)
        begin
            if (fin && (seen_reg < SEEN_MAX))
            begin
                hit = 1'b1;
                st  = ST_SMALL;
            end
            else
            begin
                unique case (phase_reg)
                    PH_START:
                    begin
                        phase_next = (b == MARK_PREFIX) ? PH_SOI2 : PH_BAD_SOI;
                    end
                    PH_SOI2:
                    begin
                        phase_next = (b == MARK_SOI) ? PH_SCAN : PH_BAD_SOI;
                    end
                    PH_BAD_SOI:
                    begin
                        if (seen_reg == SEEN_MAX)
                        begin
                            hit = 1'b1;
                            st  = ST_NO_SOI;
                        end
                    end
                    PH_FILL:
                    begin
                        if (b == MARK_PREFIX)
                        begin
                            hit = fin;
                            st  = ST_NO_SOF;
                        end
                        else if ((b == MARK_EOI) || (b == MARK_SOS))
                        begin
                            hit = 1'b1;
                            st  = ST_NO_SOF;
                        end
                        else if ((b >= MARK_RST_LO) && (b <= MARK_RST_HI))
                        begin
                            phase_next = PH_SCAN;
                            hit        = fin;
                            st         = ST_NO_SOF;
                        end
                        else if (fin)
                        begin
                            hit = 1'b1;
                            st  = ST_TRUNC_LEN;
                        end
                        else
                        begin
                            sof_next   = is_frame_marker(b);
                            phase_next = PH_LEN_HI;
                        end
                    end
                    PH_LEN_HI:
                    begin
                        if (fin)
                        begin
                            hit = 1'b1;
                            st  = ST_TRUNC_LEN;
                        end
                        else
                        begin
                            seglen_next = {b, 8'h00};
                            phase_next  = PH_LEN_LO;
                        end
                    end
                    PH_LEN_LO:
                    begin
                        seglen_next = seglen_full;
                        if (seglen_full < LEN_MIN)
                        begin
                            hit = 1'b1;
                            st  = ST_BAD_LEN;
                        end
                        else if (seglen_full == LEN_MIN)
                        begin
                            if (sof_reg)
                            begin
                                hit = 1'b1;
                                st  = ST_BAD_SOF;
                            end
                            else
                            begin
                                phase_next = PH_SCAN;
                                hit        = fin;
                                st         = ST_NO_SOF;
                            end
                        end
                        else if (fin)
                        begin
                            hit = 1'b1;
                            st  = ST_TRUNC_PAY;
                        end
                        else
                        begin
                            left_next   = pl;
                            offset_next = 3'd0;
                            height_next = 16'd0;
                            width_next  = 16'd0;
                            phase_next  = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        // Capture the dimension bytes by their offset.
                        case (offset_reg)
                            OFF_HEIGHT_HI: height_next = {b, height_reg[7:0]};
                            OFF_HEIGHT_LO: height_next = {height_reg[15:8], b};
                            OFF_WIDTH_HI:  width_next  = {b, width_reg[7:0]};
                            OFF_WIDTH_LO:  width_next  = {width_reg[15:8], b};
                            default:       ;
                        endcase
                        if (offset_reg < OFF_MAX)
                        begin
                            offset_next = offset_reg + 3'd1;
                        end
                        left_next = left_dec;
                        if (left_dec != 16'd0)
                        begin
                            hit = fin;
                            st  = ST_TRUNC_PAY;
                        end
                        else if (sof_reg)
                        begin
                            hit = 1'b1;
                            if (seglen_reg < LEN_SOF_MIN)
                            begin
                                st = ST_BAD_SOF;
                            end
                            else if ((width_next == 16'd0) || (height_next == 16'd0))
                            begin
                                st = ST_ZERO_DIM;
                            end
                            else
                            begin
                                st = ST_OK;
                            end
                        end
                        else
                        begin
                            phase_next = PH_SCAN;
                            hit        = fin;
                            st         = ST_NO_SOF;
                        end
                    end
                    PH_SCAN:
                    begin
                        if (fin)
                        begin
                            hit = 1'b1;
                            st  = ST_NO_SOF;
                        end
                        else if (b == MARK_PREFIX)
                        begin
                            phase_next = PH_FILL;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_START;
                    end
                endcase
            end
            if (hit)
            begin
                given_next = 1'b1;
            end
        end

        // Dimensions for the result, taken before the end-of-file clear.
        dim_width  = width_next;
        dim_height = height_next;

        // The final byte of a file returns everything to the start of file.
        if (fin)
        begin
            phase_next  = PH_START;
            seen_next   = 2'd0;
            seglen_next = 16'd0;
            left_next   = 16'd0;
            offset_next = 3'd0;
            sof_next    = 1'b0;
            height_next = 16'd0;
            width_next  = 16'd0;
            given_next  = 1'b0;
        end
    end

    // Result fields; dimensions only when the frame header was good.
    always_comb
    begin
        res_valid  = advance && hit;
        res.status = st;
        res.width  = (st == ST_OK) ? dim_width  : 16'd0;
        res.height = (st == ST_OK) ? dim_height : 16'd0;
    end

    // Parse state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            seen_reg   <= 2'd0;
            seglen_reg <= 16'd0;
            left_reg   <= 16'd0;
            offset_reg <= 3'd0;
            sof_reg    <= 1'b0;
            height_reg <= 16'd0;
            width_reg  <= 16'd0;
            given_reg  <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            seen_reg   <= seen_next;
            seglen_reg <= seglen_next;
            left_reg   <= left_next;
            offset_reg <= offset_next;
            sof_reg    <= sof_next;
            height_reg <= height_next;
            width_reg  <= width_next;
            given_reg  <= given_next;
        end
    end

endmodule

`default_nettype wire

### src/jsd_out_reg.sv
// Result register of the JPEG SOF dimension scanner.
// Holds one result until the receiver takes it. Depends on jsd_pkg.
`default_nettype none

module jsd_out_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire jsd_pkg::result_t load_res,
    input  wire logic             out_stall,
    output logic                  out_valid,
    output logic                  room,
    output jsd_pkg::result_t      out_res
);
    import jsd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // A new result may enter when the register is empty or being emptied.
    assign room       = !valid_reg || !out_stall;
    assign valid_next = load || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= load_res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

### src/jpeg_sof_dimension_scanner.sv
// JPEG SOF dimension scanner, top level.
// Ties together jsd_in_reg, jsd_parser and jsd_out_reg; depends on jsd_pkg.
//
// Usage:
//   Input channel: in_valid, in_stall, data_byte, final_byte. One byte of a
//   JPEG file moves per transfer; final_byte marks the last byte of a file.
//   Output channel: out_valid, out_stall, status, width, height. Exactly one
//   result transfer per file; width and height are zero unless status is 0.
//   A byte taken is held in the input register; the parser settles its result
//   combinationally, and the result register then offers that result.
//   Throughput: one byte per cycle while no result waits under out_stall, set
//   by the input register feeding the parser step and the result register.
//   Bytes after a file's result are consumed and dropped up to the final
//   byte, which returns the parse state to the start of file.
//   Stall: while a result waits under out_stall, the parser holds; the input
//   register still takes a byte if it is empty, then in_stall rises until the result
//   leaves.
//   Reset: rst_n clears both registers' valid flags and all parse state; the
//   block can accept a byte as soon as reset is released.
`default_nettype none

module jpeg_sof_dimension_scanner (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        final_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       status,
    output logic [15:0]      width,
    output logic [15:0]      height
);
    import jsd_pkg::*;

    item_t   in_item;
    item_t   held_item;
    logic    held_valid;
    logic    advance;
    logic    room;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign in_item.data = data_byte;
    assign in_item.fin  = final_byte;

    // The held byte is parsed when the result register can take a result.
    assign advance = held_valid && room;

    jsd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    jsd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (held_item),
        .res_valid (res_valid),
        .res       (res)
    );

    jsd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .load_res  (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .room      (room),
        .out_res   (out_res)
    );

    assign status = out_res.status;
    assign width  = out_res.width;
    assign height = out_res.height;

    // A waiting result must freeze the parser.
    a_hold_parser: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !advance)
        else $error("parser advanced while a result was stalled");

    // The input side only stalls with a byte held.
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> held_valid)
        else $error("input stalled with empty input register");

    // A good result carries nonzero dimensions.
    a_ok_dims: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_OK)) |-> ((width != 16'd0) && (height != 16'd0)))
        else $error("ok result with zero dimension");

    // Any other result carries zero dimensions.
    a_err_dims: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> ((width == 16'd0) && (height == 16'd0)))
        else $error("error result with nonzero dimension");

endmodule

`default_nettype wire

### dv/sof_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the JPEG SOF dimension scanner testbench.
// Mirrors the byte parser, queues the expected result of each file and compares
// every result transfer with it. Depends on jsd_pkg.
module sof_result_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        final_byte,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [3:0]  status,
    input  wire logic [15:0] width,
    input  wire logic [15:0] height,
    output int               mismatches,
    output int               pending
);
    import jsd_pkg::*;

    // Shadow copy of the parse state.
    phase_t      scan_phase;
    logic [1:0]  byte_count;
    logic [15:0] seg_len;
    logic [15:0] body_left;
    logic [2:0]  body_offset;
    logic        in_frame_seg;
    logic [15:0] frame_height;
    logic [15:0] frame_width;
    logic        file_done;

    // Results predicted but not yet seen, oldest first.
    result_t     expected_results[$];
    result_t     oldest;

    function automatic logic starts_frame(input logic [7:0] m);
        return (m >= MARK_SOF_LO) && (m <= MARK_SOF_HI) &&
               (m != MARK_DHT) && (m != MARK_JPG) && (m != MARK_DAC);
    endfunction

    task automatic clear_parse();
        scan_phase   = PH_START;
        byte_count   = 2'd0;
        seg_len      = 16'd0;
        body_left    = 16'd0;
        body_offset  = 3'd0;
        in_frame_seg = 1'b0;
        frame_height = 16'd0;
        frame_width  = 16'd0;
        file_done    = 1'b0;
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Advances the shadow parser by one byte and queues the file's result
    // once it is settled.
    task automatic parse_byte(input logic [7:0] b, input logic fin);
        logic [1:0]  idx;
        logic        hit;
        status_t     st;
        logic [15:0] body;
        result_t     r;
        idx  = byte_count;
        hit  = 1'b0;
        st   = ST_OK;
        body = 16'd0;
        if (byte_count < SEEN_MAX)
            byte_count = byte_count + 2'd1;
        if (!file_done)
        begin
            // A final byte among the first three always means a short file.
            if (fin && idx < SEEN_MAX)
            begin
                hit = 1'b1; st = ST_SMALL;
            end
            else
            begin
                case (scan_phase)
                    PH_START:
                        scan_phase = (b == MARK_PREFIX) ? PH_SOI2 : PH_BAD_SOI;
                    PH_SOI2:
                        scan_phase = (b == MARK_SOI) ? PH_SCAN : PH_BAD_SOI;
                    PH_BAD_SOI:
                        if (idx >= SEEN_MAX)
                        begin
                            hit = 1'b1; st = ST_NO_SOI;
                        end
                    PH_FILL:
                    begin
                        if (b == MARK_PREFIX)
                        begin
                            if (fin)
                            begin
                                hit = 1'b1; st = ST_NO_SOF;
                            end
                        end
                        else if (b == MARK_EOI || b == MARK_SOS)
                        begin
                            hit = 1'b1; st = ST_NO_SOF;
                        end
                        else if (b >= MARK_RST_LO && b <= MARK_RST_HI)
                        begin
                            scan_phase = PH_SCAN;
                            if (fin)
                            begin
                                hit = 1'b1; st = ST_NO_SOF;
                            end
                        end
                        else if (fin)
                        begin
                            hit = 1'b1; st = ST_TRUNC_LEN;
                        end
                        else
                        begin
                            in_frame_seg = starts_frame(b);
                            scan_phase   = PH_LEN_HI;
                        end
                    end
                    PH_LEN_HI:
                        if (fin)
                        begin
                            hit = 1'b1; st = ST_TRUNC_LEN;
                        end
                        else
                        begin
                            seg_len    = {b, 8'h00};
                            scan_phase = PH_LEN_LO;
                        end
                    PH_LEN_LO:
                    begin
                        seg_len[7:0] = b;
                        if (seg_len < LEN_MIN)
                        begin
                            hit = 1'b1; st = ST_BAD_LEN;
                        end
                        else
                        begin
                            body = seg_len - LEN_MIN;
                            if (body == 16'd0)
                            begin
                                if (in_frame_seg)
                                begin
                                    hit = 1'b1; st = ST_BAD_SOF;
                                end
                                else
                                begin
                                    scan_phase = PH_SCAN;
                                    if (fin)
                                    begin
                                        hit = 1'b1; st = ST_NO_SOF;
                                    end
                                end
                            end
                            else if (fin)
                            begin
                                hit = 1'b1; st = ST_TRUNC_PAY;
                            end
                            else
                            begin
                                body_left    = body;
                                body_offset  = 3'd0;
                                frame_height = 16'd0;
                                frame_width  = 16'd0;
                                scan_phase   = PH_PAYLOAD;
                            end
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        case (body_offset)
                            OFF_HEIGHT_HI: frame_height[15:8] = b;
                            OFF_HEIGHT_LO: frame_height[7:0]  = b;
                            OFF_WIDTH_HI:  frame_width[15:8]  = b;
                            OFF_WIDTH_LO:  frame_width[7:0]   = b;
                            default: ;
                        endcase
                        if (body_offset < OFF_MAX)
                            body_offset = body_offset + 3'd1;
                        body_left = body_left - 16'd1;
                        // A frame segment is judged only once its whole body is in.
                        if (body_left != 16'd0)
                        begin
                            if (fin)
                            begin
                                hit = 1'b1; st = ST_TRUNC_PAY;
                            end
                        end
                        else if (in_frame_seg)
                        begin
                            hit = 1'b1;
                            if (seg_len < LEN_SOF_MIN)
                                st = ST_BAD_SOF;
                            else if (frame_width == 16'd0 || frame_height == 16'd0)
                                st = ST_ZERO_DIM;
                            else
                                st = ST_OK;
                        end
                        else
                        begin
                            scan_phase = PH_SCAN;
                            if (fin)
                            begin
                                hit = 1'b1; st = ST_NO_SOF;
                            end
                        end
                    end
                    default:
                        if (fin)
                        begin
                            hit = 1'b1; st = ST_NO_SOF;
                        end
                        else if (b == MARK_PREFIX)
                            scan_phase = PH_FILL;
                endcase
            end
            if (hit)
            begin
                r.status  = st;
                r.width   = (st == ST_OK) ? frame_width : 16'd0;
                r.height  = (st == ST_OK) ? frame_height : 16'd0;
                expected_results.push_back(r);
                file_done = 1'b1;
            end
        end
        // The final byte returns everything to the start of a file.
        if (fin)
            clear_parse();
    endtask

    // Watch both channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parse();
            expected_results.delete();
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected result, status %0d", status));
                else
                begin
                    oldest = expected_results.pop_front();
                    if (status !== oldest.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, oldest.status));
                    if (width !== oldest.width)
                        report_mismatch($sformatf("width %0d, expected %0d",
                                                  width, oldest.width));
                    if (height !== oldest.height)
                        report_mismatch($sformatf("height %0d, expected %0d",
                                                  height, oldest.height));
                end
            end
            if (in_valid && !in_stall)
                parse_byte(data_byte, final_byte);
            pending = expected_results.size();
        end
    end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// Top of the JPEG SOF dimension scanner testbench.
// Builds JPEG byte files, drives them with random idling and stalls, and gives
// the verdict. Depends on jsd_pkg, sof_result_checker and the scanner.
module testbench;
    import jsd_pkg::*;

    // SOF_PROG starts a frame; the other markers are plain to the scanner.
    localparam logic [7:0] MARK_APP0     = 8'hE0;
    localparam logic [7:0] MARK_APP1     = 8'hE1;
    localparam logic [7:0] MARK_COM      = 8'hFE;
    localparam logic [7:0] MARK_SOF_PROG = 8'hC2;

    localparam int RANDOM_END = 1780;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  data_byte = 8'h00;
    logic        final_byte = 1'b0;
    logic        out_stall = 1'b0;
    wire         in_stall;
    wire         out_valid;
    wire  [3:0]  status;
    wire  [15:0] width;
    wire  [15:0] height;

    int          mismatches;
    int          pending;
    int          tx_idle_pct;
    int          rx_stall_pct;
    int          bytes_sent;
    int          drain;
    logic [7:0]  file_bytes[$];

    jpeg_sof_dimension_scanner u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .width      (width),
        .height     (height)
    );

    sof_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .width      (width),
        .height     (height),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #1 clk = ~clk;

    // Receiver stalls at random.
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < rx_stall_pct);

    // One byte transfer, after a random number of idle cycles.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (bytes_sent < 650)
        begin
            tx_idle_pct  = 18;
            rx_stall_pct = 68;
        end
        else if (bytes_sent < 1300)
        begin
            tx_idle_pct  = 68;
            rx_stall_pct = 18;
        end
        else
        begin
            tx_idle_pct  = 0;
            rx_stall_pct = 0;
        end
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        final_byte <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Sends the built file, flagging its last byte.
    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        file_bytes.delete();
    endtask

    // Marker, length and body; body bytes 1..4 carry height and width.
    task automatic add_segment(input logic [7:0] marker, input logic [15:0] len,
                               input logic [15:0] hgt, input logic [15:0] wid);
        logic [7:0] b;
        file_bytes.push_back(MARK_PREFIX);
        file_bytes.push_back(marker);
        file_bytes.push_back(len[15:8]);
        file_bytes.push_back(len[7:0]);
        for (int i = 0; i + 2 < int'(len); i++)
        begin
            case (i)
                OFF_HEIGHT_HI: b = hgt[15:8];
                OFF_HEIGHT_LO: b = hgt[7:0];
                OFF_WIDTH_HI:  b = wid[15:8];
                OFF_WIDTH_LO:  b = wid[7:0];
                default:       b = 8'($urandom_range(255));
            endcase
            file_bytes.push_back(b);
        end
    endtask

    function automatic logic [15:0] pick_dim();
        int r;
        r = $urandom_range(99);
        if (r < 12)
            return 16'd0;
        if (r < 20)
            return 16'hFFFF;
        if (r < 60)
            return 16'($urandom_range(1, 255));
        return 16'($urandom_range(65535));
    endfunction

    // Mostly well-formed files with random content, some damaged, some noise.
    task automatic build_random_file();
        int          kind;
        int          cut;
        logic [7:0]  m;
        logic [15:0] len;
        kind = $urandom_range(99);
        if (kind < 8)
        begin
            repeat ($urandom_range(1, 12))
                file_bytes.push_back(8'($urandom_range(255)));
            if ($urandom_range(1) == 1)
                file_bytes[0] = MARK_PREFIX;
            return;
        end
        file_bytes.push_back(MARK_PREFIX);
        file_bytes.push_back(MARK_SOI);
        repeat ($urandom_range(0, 3))
        begin
            kind = $urandom_range(99);
            if (kind < 15)
            begin
                repeat ($urandom_range(1, 3))
                    file_bytes.push_back(MARK_PREFIX);
            end
            else if (kind < 30)
            begin
                file_bytes.push_back(MARK_PREFIX);
                file_bytes.push_back(8'(MARK_RST_LO + $urandom_range(7)));
            end
            else
            begin
                m = 8'($urandom_range(255));
                if (m == MARK_PREFIX || m == MARK_EOI || m == MARK_SOS ||
                    (m >= MARK_RST_LO && m <= MARK_RST_HI))
                    m = MARK_APP0;
                if (kind < 33)
                begin
                    // Long segment that the file cuts short.
                    len = 16'($urandom_range(16'h0100, 16'hFFFF));
                    file_bytes.push_back(MARK_PREFIX);
                    file_bytes.push_back(m);
                    file_bytes.push_back(len[15:8]);
                    file_bytes.push_back(len[7:0]);
                    repeat ($urandom_range(0, 6))
                        file_bytes.push_back(8'($urandom_range(255)));
                    return;
                end
                if ($urandom_range(99) < 4)
                    len = 16'($urandom_range(1));
                else
                    len = 16'($urandom_range(2, 14));
                add_segment(m, len, pick_dim(), pick_dim());
            end
        end
        // Frame header.
        if ($urandom_range(99) < 85)
        begin
            do
                m = 8'($urandom_range(MARK_SOF_LO, MARK_SOF_HI));
            while (m == MARK_DHT || m == MARK_JPG || m == MARK_DAC);
            if ($urandom_range(99) < 10)
                len = 16'($urandom_range(2, 7));
            else
                len = 16'($urandom_range(8, 17));
            add_segment(m, len, pick_dim(), pick_dim());
        end
        // Tail of the file.
        kind = $urandom_range(99);
        if (kind < 40)
        begin
            file_bytes.push_back(MARK_PREFIX);
            file_bytes.push_back(MARK_EOI);
        end
        else if (kind < 60)
        begin
            file_bytes.push_back(MARK_PREFIX);
            file_bytes.push_back(MARK_SOS);
            repeat ($urandom_range(0, 5))
                file_bytes.push_back(8'($urandom_range(255)));
        end
        else if (kind < 80)
        begin
            repeat ($urandom_range(1, 6))
                file_bytes.push_back(8'($urandom_range(255)));
        end
        // Damage: cut the file short or corrupt one byte.
        kind = $urandom_range(99);
        if (kind < 15)
        begin
            cut = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > cut)
                void'(file_bytes.pop_back());
        end
        else if (kind < 25)
            file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom_range(255));
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Short files.
        file_bytes = '{MARK_PREFIX};
        send_file();
        file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX};
        send_file();
        // Bad start of image, reported on the fourth byte.
        file_bytes = '{8'h00, MARK_SOI, 8'h00, 8'h00};
        send_file();
        file_bytes = '{MARK_PREFIX, 8'h00, 8'h12, 8'h34, 8'h56};
        send_file();
        // Search ending without a frame header.
        file_bytes = '{MARK_PREFIX, MARK_SOI, 8'h00, 8'h00};
        send_file();
        file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_EOI, 8'h12, 8'h34};
        send_file();
        file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_SOS};
        send_file();
        file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_PREFIX, MARK_PREFIX};
        send_file();
        file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_RST_LO, MARK_PREFIX,
                       MARK_RST_HI, 8'h00};
        send_file();
        file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_RST_HI};
        send_file();
        // Truncated and bad segment lengths.
        file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_APP0};
        send_file();
        file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_APP0, 8'h00};
        send_file();
        file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_APP1, 8'h00, 8'h01};
        send_file();
        file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_APP0, 8'h00, 8'h00};
        send_file();
        // Empty segments: skipped unless they are frame headers.
        file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_DHT, 8'h00, 8'h02,
                       MARK_PREFIX, MARK_JPG, 8'h00, 8'h02};
        send_file();
        file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_SOF_LO, 8'h00, 8'h02};
        send_file();
        // Truncated bodies.
        file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_COM, 8'h00, 8'h05, 8'h11};
        send_file();
        file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_COM, 8'h00, 8'h05};
        send_file();
        file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_SOF_PROG, 8'hFF, 8'hFF,
                       8'h00, 8'hAA};
        send_file();
        // Frame header too short, then zero dimensions.
        file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_SOF_PROG, 8'h00, 8'h07,
                       8'h08, 8'h00, 8'h10, 8'h00, 8'h10};
        send_file();
        file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_SOF_HI, 8'h00, 8'h08,
                       8'h08, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01};
        send_file();
        file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_SOF_LO, 8'h00, 8'h08,
                       8'h08, 8'h00, 8'h00, 8'h00, 8'h05, 8'h01};
        send_file();
        // Good frames: largest dimensions with bytes after the result, then
        // the smallest with fill bytes and the result on the final byte.
        file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_DAC, 8'h00, 8'h02,
                       MARK_PREFIX, MARK_SOF_HI, 8'h00, 8'h0B, 8'h08, 8'hFF, 8'hFF,
                       8'hFF, 8'hFF, 8'h03, 8'h01, 8'h11, 8'h00, MARK_PREFIX, MARK_EOI};
        send_file();
        file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_PREFIX, MARK_SOF_LO,
                       8'h00, 8'h08, 8'h08, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00};
        send_file();

        // Random files.
        while (bytes_sent < RANDOM_END)
        begin
            build_random_file();
            send_file();
        end

        // Drain the remaining results.
        @(negedge clk);
        in_valid <= 1'b0;
        drain = 0;
        while (pending != 0 && drain < 100000)
        begin
            @(negedge clk);
            drain++;
        end
        repeat (8) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Run limit.
    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
src/jsd_pkg.sv
src/jsd_in_reg.sv
src/jsd_parser.sv
src/jsd_out_reg.sv
src/jpeg_sof_dimension_scanner.sv
dv/sof_result_checker.sv
dv/testbench.sv
